// File: rtl/core/chfi_pkg.sv
package chfi_pkg;
  localparam int BUCKETS   = 1024;
  localparam int ENTRIES   = 1024;
  localparam int KEY_BYTES = 8;
  localparam int BW = $clog2(BUCKETS);
  localparam int EW = $clog2(ENTRIES);
  localparam int KW = KEY_BYTES * 8;
  localparam int CW = EW + 1;
  localparam int CLRN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CLRW = $clog2(CLRN);

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [BW-1:0] bucket;
    logic [KW-1:0] key;
    logic [KW-1:0] mask;
  } req_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HEAD, S_ENT, S_CMP, S_OUT
  } bstate_t;

  function automatic logic [KW-1:0] key_mask(input logic [3:0] len);
    logic [3:0] n;
    logic [KW-1:0] m;
    n = (len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : len;
    for (int i = 0; i < KEY_BYTES; i++) begin
      m[i*8 +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction
endpackage

// File: rtl/core/chfi_front.sv
module chfi_front
  import chfi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [BW-1:0] in_bucket,
  input  logic [KW-1:0] in_key,
  input  logic [3:0]    key_length,
  output logic          q_valid,
  input  logic          q_ready,
  output req_t          q_data
);
  req_t buf0, buf1;
  logic [1:0] cnt;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = buf0;

  req_t nreq;
  always_comb begin
    nreq.bucket = in_bucket;
    nreq.key    = in_key;
    nreq.mask   = key_mask(key_length);
  end

  logic push, pop;
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (pop) begin
      buf0 <= buf1;
      if (push && cnt == 2'd1) buf0 <= nreq;
      if (push && cnt == 2'd2) buf1 <= nreq;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= nreq;
      else buf1 <= nreq;
    end
  end
endmodule

// File: rtl/core/chfi_back.sv
module chfi_back
  import chfi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  req_t          q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [9:0]    out_index,
  output logic [1:0]    out_status
);
  logic [EW:0]   heads   [BUCKETS];
  logic [KW-1:0] keys    [ENTRIES];
  logic [EW:0]   links   [ENTRIES];
  logic [BW-1:0] hashes  [ENTRIES];

  bstate_t state, state_next;
  req_t req;
  logic [CW-1:0] next_free;
  logic [EW:0] head_rd, link_rd;
  logic [KW-1:0] key_rd;
  logic [EW-1:0] cur;
  logic tail_is_head;
  logic [EW-1:0] tail_ent;
  logic [CW-1:0] steps;
  logic [CLRW-1:0] clr_idx;

  assign cur = tail_is_head ? head_rd[EW-1:0] : link_rd[EW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (int'(clr_idx) == CLRN - 1) state_next = S_IDLE;
      S_IDLE: if (q_valid) state_next = S_HEAD;
      S_HEAD: state_next = S_ENT;
      S_ENT:  state_next = S_CMP;
      S_CMP:  state_next = S_ENT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_ENT) begin
      if (!(tail_is_head ? head_rd[EW] : link_rd[EW]) || steps >= CW'(ENTRIES))
        state_next = S_OUT;
    end
    if (state == S_CMP && ((key_rd ^ req.key) & req.mask) == '0)
      state_next = S_OUT;
  end

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      next_free <= '0;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_idx <= clr_idx + 1'b1;
      if (state == S_ENT && state_next == S_OUT && next_free < CW'(ENTRIES))
        next_free <= next_free + 1'b1;
    end
    case (state)
      S_CLR: begin
        if (int'(clr_idx) < BUCKETS) heads[clr_idx[BW-1:0]] <= '0;
        if (int'(clr_idx) < ENTRIES) links[clr_idx[EW-1:0]] <= '0;
      end
      S_IDLE: if (q_valid) req <= q_data;
      S_HEAD: begin
        head_rd <= heads[req.bucket];
        tail_is_head <= 1'b1;
        steps <= '0;
      end
      S_ENT: begin
        if (state_next == S_OUT) begin
          if (next_free < CW'(ENTRIES)) begin
            keys[next_free[EW-1:0]] <= req.key;
            hashes[next_free[EW-1:0]] <= req.bucket;
            if (tail_is_head) heads[req.bucket] <= {1'b1, next_free[EW-1:0]};
            else links[tail_ent] <= {1'b1, next_free[EW-1:0]};
            out_index <= 10'(next_free[EW-1:0]);
            out_status <= ST_ADDED;
          end else begin
            out_index <= '0;
            out_status <= ST_FULL;
          end
        end else begin
          key_rd <= keys[cur];
          link_rd <= links[cur];
          tail_ent <= cur;
        end
      end
      S_CMP: begin
        tail_is_head <= 1'b0;
        steps <= steps + 1'b1;
        out_index <= 10'(tail_ent);
        out_status <= ST_FOUND;
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/core/chained_hash_find_or_insert.sv
// Chained hash table find-or-insert.
// s_axis: one beat per lookup; tdata = {key[63:0], bucket_hash[9:0]}.
// m_axis: one beat per lookup; tdata = {status[1:0], entry_index[9:0]}.
// cfg: key_length write (1..8 bytes compared); write only while idle.
// A two-deep queue in front takes beats while the back end walks a chain.
// Back end, one lookup at a time: it takes a beat and reads the bucket
// head, then for each chain entry visited reads the entry and compares
// the key, and ends with an output state.
// On a miss a fresh entry is taken from the bump allocator and linked at
// the tail; once all entries are used the result is status 2, index 0.
// The result stays in the output register until m_axis_tready; the back end
// stalls meanwhile, and the front queue keeps accepting until full.
// After reset a clearing pass zeroes the bucket heads and entry links;
// s_axis takes at most two beats meanwhile. Reset also clears the
// allocator and sets key_length = 8.
module chained_hash_find_or_insert
  import chfi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // bucket_hash[9:0], lookup_key[73:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // entry_index[9:0], status[11:10]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  logic [3:0] key_length;
  logic q_valid, q_ready;
  req_t q_data;
  logic [9:0] idx;
  logic [1:0] st;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) key_length <= 4'd8;
    else if (cfg_valid) key_length <= cfg_data;
  end

  chfi_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_bucket(s_axis_tdata[BW-1:0]), .in_key(s_axis_tdata[10 +: KW]),
    .key_length, .q_valid, .q_ready, .q_data
  );

  chfi_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_index(idx), .out_status(st)
  );

  assign m_axis_tdata = {4'b0, st, idx};
endmodule
